@@ rtl/pcrs_pkg.sv @@
// Shared types and constants for the prefix count / rank select block.
// No dependencies; imported by pcrs_ctrl and prefix_count_rank_select.
package pcrs_pkg;

	localparam int MAX_POS = 1024;                    // positions covered at most
	localparam int POS_W   = 11;                      // position field width
	localparam int SIZE_W  = 11;                      // size register width
	localparam int DATA_W  = 32;                      // node, delta, answer width
	localparam int ADDR_W  = $clog2(MAX_POS + 1);     // node address width
	localparam int DEPTH   = MAX_POS + 1;             // node 0 unused

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_POS);

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_SUM   = 2'd1,
		OP_FIND  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	// node store access from the sequencer
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// finished result offered to the output register
	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] answer;
	} result_t;

endpackage

@@ rtl/pcrs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pcrs_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/pcrs_ctrl.sv @@
// Sequencer for the tree walks, the find search and the clearing sweep.
// Depends on pcrs_pkg; drives the node RAM and reads its registered data.
module pcrs_ctrl
	import pcrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        operation,
	input  logic [POS_W-1:0]  position,
	input  logic [DATA_W-1:0] operand_value,
	input  logic [ADDR_W-1:0] size,
	output result_t           res,
	input  logic              res_take,
	output ram_req_t          ram_req,
	input  logic [DATA_W-1:0] rdata
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_ADD   = 7'b0000010,
		ST_SUM   = 7'b0000100,
		ST_FCMP  = 7'b0001000,
		ST_FNEXT = 7'b0010000,
		ST_CLR   = 7'b0100000,
		ST_RESP  = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] addr_q, addr_d;
	logic [ADDR_W-1:0] lo_q, lo_d, hi_q, hi_d;
	logic [DATA_W-1:0] acc_q, acc_d, val_q, val_d, ans_q, ans_d;
	logic              find_q, find_d, clr_resp_q, clr_resp_d;

	logic [ADDR_W:0]   addr_ext, up_next, size_ext, mid_sum;
	logic [ADDR_W-1:0] dn_next, mid, sum_idx;
	logic [DATA_W-1:0] sum_total;
	logic              span_gt1, add_ok;

	assign addr_ext  = {1'b0, addr_q};
	assign size_ext  = {1'b0, size};
	// parent going up: add the lowest set bit
	assign up_next   = addr_ext + (addr_ext & (~addr_ext + (ADDR_W+1)'(1)));
	// next node going down: drop the lowest set bit
	assign dn_next   = addr_q & (addr_q - ADDR_W'(1));
	assign sum_total = acc_q + rdata;
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[ADDR_W:1];
	assign span_gt1  = {1'b0, hi_q} > ({1'b0, lo_q} + (ADDR_W+1)'(1));
	assign add_ok    = (position != '0) && ({1'b0, position} <= size_ext);
	assign sum_idx   = ({1'b0, position} > size_ext) ? size : ADDR_W'(position);

	assign in_ready   = (state_q == ST_IDLE);
	assign res.valid  = (state_q == ST_RESP);
	assign res.answer = ans_q;

	always_comb begin
		state_d       = state_q;
		addr_d        = addr_q;
		lo_d          = lo_q;
		hi_d          = hi_q;
		acc_d         = acc_q;
		val_d         = val_q;
		ans_d         = ans_q;
		find_d        = find_q;
		clr_resp_d    = clr_resp_q;
		ram_req.we    = 1'b0;
		ram_req.waddr = addr_q;
		ram_req.wdata = rdata + val_q;
		ram_req.raddr = addr_q;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (op_t'(operation))
						OP_ADD: begin
							val_d = operand_value;
							if (add_ok) begin
								ram_req.raddr = ADDR_W'(position);
								addr_d        = ADDR_W'(position);
								state_d       = ST_ADD;
							end else begin
								ans_d   = '0;
								state_d = ST_RESP;
							end
						end
						OP_SUM: begin
							find_d = 1'b0;
							acc_d  = '0;
							if (sum_idx != '0) begin
								ram_req.raddr = sum_idx;
								addr_d        = sum_idx;
								state_d       = ST_SUM;
							end else begin
								ans_d   = '0;
								state_d = ST_RESP;
							end
						end
						OP_FIND: begin
							val_d   = operand_value;
							lo_d    = '0;
							hi_d    = size;
							find_d  = 1'b1;
							state_d = ST_FNEXT;
						end
						OP_CLEAR: begin
							addr_d     = '0;
							clr_resp_d = 1'b1;
							state_d    = ST_CLR;
						end
					endcase
				end
			end
			ST_ADD: begin
				// rdata holds node addr_q; write it back and fetch the parent
				ram_req.we = 1'b1;
				if (up_next <= size_ext) begin
					ram_req.raddr = up_next[ADDR_W-1:0];
					addr_d        = up_next[ADDR_W-1:0];
				end else begin
					ans_d   = '0;
					state_d = ST_RESP;
				end
			end
			ST_SUM: begin
				acc_d = sum_total;
				if (dn_next != '0) begin
					ram_req.raddr = dn_next;
					addr_d        = dn_next;
				end else if (find_q) begin
					state_d = ST_FCMP;
				end else begin
					ans_d   = sum_total;
					state_d = ST_RESP;
				end
			end
			ST_FCMP: begin
				// lo and hi are unchanged during the walk, so mid is still the probe
				if ($signed(acc_q) >= $signed(val_q)) begin
					hi_d = mid;
				end else begin
					lo_d = mid;
				end
				state_d = ST_FNEXT;
			end
			ST_FNEXT: begin
				if (span_gt1) begin
					ram_req.raddr = mid;
					addr_d        = mid;
					acc_d         = '0;
					state_d       = ST_SUM;
				end else begin
					ans_d   = {{(DATA_W-ADDR_W){1'b0}}, hi_q};
					state_d = ST_RESP;
				end
			end
			ST_CLR: begin
				ram_req.we    = 1'b1;
				ram_req.wdata = '0;
				if (addr_q == ADDR_W'(MAX_POS)) begin
					if (clr_resp_q) begin
						ans_d   = '0;
						state_d = ST_RESP;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					addr_d = addr_q + ADDR_W'(1);
				end
			end
			ST_RESP: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			addr_q     <= '0;
			clr_resp_q <= 1'b0;
			find_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			addr_q     <= addr_d;
			clr_resp_q <= clr_resp_d;
			find_q     <= find_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		acc_q <= acc_d;
		val_q <= val_d;
		ans_q <= ans_d;
	end

endmodule

@@ rtl/prefix_count_rank_select.sv @@
// Top level of the prefix count / rank select block (Fenwick tree).
// Depends on pcrs_pkg, pcrs_ram and pcrs_ctrl.

// Binary indexed tree over positions 1..size, nodes held in one 1025 x 32
// RAM with a registered read. Each input word gives exactly one answer
// word. One operation is worked at a time; the next input word is taken
// once the current answer sits in the output register, even if that
// register has not yet been drained. Add walks up the tree and prefix sum
// walks down it, each visiting at most about log2(size)+1 nodes; find runs
// a binary search in which every probe is a full prefix walk. Clear sweeps
// every RAM entry, one per cycle. The same sweep runs after reset; in_ready
// stays low for it while configuration writes are still taken.
// The single register size_in_use may be written at any time the block is
// idle; 0 acts as 1 and values above 1024 act as 1024. Sums wrap modulo
// 2^32; find compares them as signed values with the target.
module prefix_count_rank_select
	import pcrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// input words
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        operation,
	input  logic [POS_W-1:0]  position,
	input  logic [DATA_W-1:0] operand_value,
	// answer words
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] answer,
	// configuration write
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] size_in_use
);

	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] eff_size;
	result_t           res;
	logic              res_take;
	ram_req_t          ram_req;
	logic [DATA_W-1:0] rdata;
	logic              out_valid_q;
	logic [DATA_W-1:0] answer_q;

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_valid) begin
			size_q <= size_in_use;
		end
	end

	// zero acts as one, too large clamps to the store size
	always_comb begin
		priority if (size_q == '0) begin
			eff_size = ADDR_W'(1);
		end else if ({1'b0, size_q} > (SIZE_W+1)'(MAX_POS)) begin
			eff_size = ADDR_W'(MAX_POS);
		end else begin
			eff_size = ADDR_W'(size_q);
		end
	end

	pcrs_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.position      (position),
		.operand_value (operand_value),
		.size          (eff_size),
		.res           (res),
		.res_take      (res_take),
		.ram_req       (ram_req),
		.rdata         (rdata)
	);

	pcrs_ram #(
		.DEPTH (DEPTH),
		.WIDTH (DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (rdata)
	);

	// output register: loads when empty or being drained this cycle
	assign res_take = res.valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			answer_q <= res.answer;
		end
	end

	assign out_valid = out_valid_q;
	assign answer    = answer_q;

endmodule

@@ tb/sv/prefix_count_checker.sv @@
// Answer checker for prefix_count_rank_select: keeps its own copy of the node
// store and size register, predicts one answer per input word, compares in order.
// Depends on pcrs_pkg.
module prefix_count_checker
	import pcrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [1:0]        operation,
	input  logic [POS_W-1:0]  position,
	input  logic [DATA_W-1:0] operand_value,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [DATA_W-1:0] answer,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [SIZE_W-1:0] size_in_use,
	output int                words_pending,
	output int                mismatches,
	output int                answers_checked
);

	typedef struct {
		op_t               op;
		logic [DATA_W-1:0] value;
	} due_t;

	logic [DATA_W-1:0] node_mem [0:MAX_POS];
	logic [SIZE_W-1:0] size_reg;
	due_t              answers_due [$];
	int                words_taken;
	int                words_returned;
	int                bad_count;
	int                good_count;

	assign words_pending   = words_taken - words_returned;
	assign mismatches      = bad_count;
	assign answers_checked = good_count + bad_count;

	// 0 acts as 1, anything above MAX_POS as MAX_POS
	function automatic int unsigned covered_size();
		int unsigned s;
		s = size_reg;
		if (s == 0)
			s = 1;
		if (s > MAX_POS)
			s = MAX_POS;
		return s;
	endfunction

	function automatic logic [DATA_W-1:0] prefix_of(int unsigned idx, int unsigned lim);
		logic [DATA_W-1:0] acc;
		acc = '0;
		if (idx > lim)
			idx = lim;
		while (idx > 0) begin
			acc += node_mem[idx];
			idx -= idx & (~idx + 1);
		end
		return acc;
	endfunction

	// applies one word to the store copy, returns the answer it gives
	function automatic logic [DATA_W-1:0] fenwick_step(op_t op, int unsigned pos,
			logic [DATA_W-1:0] val);
		int unsigned       lim;
		int unsigned       lo;
		int unsigned       hi;
		int unsigned       mid;
		logic [DATA_W-1:0] res;
		lim = covered_size();
		res = '0;
		case (op)
			OP_ADD: begin
				if (pos != 0 && pos <= lim) begin
					while (pos <= lim) begin
						node_mem[pos] += val;
						pos += pos & (~pos + 1);
					end
				end
			end
			OP_SUM: begin
				res = prefix_of(pos, lim);
			end
			OP_FIND: begin
				lo = 0;
				hi = lim;
				while (hi - lo > 1) begin
					mid = (lo + hi) >> 1;
					if ($signed(prefix_of(mid, lim)) >= $signed(val))
						hi = mid;
					else
						lo = mid;
				end
				res = DATA_W'(hi);
			end
			default: begin
				for (int i = 0; i <= MAX_POS; i++)
					node_mem[i] = '0;
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		due_t head;
		if (!arst_n) begin
			answers_due.delete();
			for (int i = 0; i <= MAX_POS; i++)
				node_mem[i] = '0;
			size_reg = SIZE_RESET;
			words_taken <= 0;
			words_returned <= 0;
			bad_count <= 0;
			good_count <= 0;
		end else begin
			// retire first: an answer never belongs to a word taken in the same cycle
			if (out_valid && out_ready) begin
				words_returned <= words_returned + 1;
				if (answers_due.size() == 0) begin
					if (bad_count < 10)
						$display("%0t: answer word 0x%08h with nothing outstanding",
							$time, answer);
					bad_count <= bad_count + 1;
				end else begin
					head = answers_due.pop_front();
					if (answer !== head.value) begin
						if (bad_count < 10)
							$display("%0t: %s answer expected %0d (0x%08h), got %0d (0x%08h)",
								$time, head.op.name(), $signed(head.value), head.value,
								$signed(answer), answer);
						bad_count <= bad_count + 1;
					end else begin
						good_count <= good_count + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				size_reg = size_in_use;
			if (in_valid && in_ready) begin
				head.op = op_t'(operation);
				head.value = fenwick_step(op_t'(operation), position, operand_value);
				answers_due.push_back(head);
				words_taken <= words_taken + 1;
			end
		end
	end

endmodule

@@ tb/sv/tb_prefix_count_rank_select.sv @@
// Testbench top for prefix_count_rank_select: clock, reset, stimulus and verdict.
// Depends on pcrs_pkg, the block's RTL and prefix_count_checker.
module tb_prefix_count_rank_select;
	import pcrs_pkg::*;

	localparam int LIMIT     = 1000000;   // watchdog, in clock cycles
	localparam int LONG_HOLD = 400;       // receiver hold-off, in cycles
	localparam int PER_PHASE = 80;        // random words per size setting
	localparam int PHASES    = 10;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        operation;
	logic [POS_W-1:0]  position;
	logic [DATA_W-1:0] operand_value;
	logic              out_valid;
	logic              out_ready;
	logic [DATA_W-1:0] answer;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [SIZE_W-1:0] size_in_use;

	int pending;
	int mismatches;
	int answers_checked;

	// stimulus-side view of the covered size, used only to shape positions
	int unsigned cur_size = MAX_POS;
	int          op_count [4] = '{0, 0, 0, 0};
	bit          no_gaps = 1'b0;      // both sides run flat out while set
	logic        long_hold = 1'b0;    // raised by stimulus, dropped by the receiver

	// register settings walked through: zero, all ones, one, a few in between,
	// full depth and other values above it; the last phase picks a random size
	int size_plan [PHASES-1] = '{0, 2047, 1, 13, 1024, 300, 1500, 64, 7};

	always #5 clk = ~clk;

	prefix_count_rank_select u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.position      (position),
		.operand_value (operand_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.answer        (answer),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.size_in_use   (size_in_use)
	);

	prefix_count_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.position        (position),
		.operand_value   (operand_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.answer          (answer),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.size_in_use     (size_in_use),
		.words_pending   (pending),
		.mismatches      (mismatches),
		.answers_checked (answers_checked)
	);

	// idle length: mostly none, some short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	// mostly inside the tree, with zero, the top, and indexes past the size
	function automatic logic [POS_W-1:0] pick_pos();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return POS_W'(cur_size);
		if (r == 2)
			return POS_W'($urandom_range(0, 2047));
		if (r == 3)
			return POS_W'($urandom_range(cur_size + 1, 2047));
		return POS_W'($urandom_range(1, cur_size));
	endfunction

	// small signed deltas keep sums in reach of find targets; extremes force wrap
	function automatic logic [DATA_W-1:0] pick_delta();
		int r;
		int d;
		r = $urandom_range(0, 24);
		d = int'($urandom_range(0, 40)) - 20;
		if (r < 18)
			return DATA_W'(d);
		if (r < 21)
			return DATA_W'($urandom_range(0, 1000));
		if (r == 21)
			return 32'h7FFF_FFFF;
		if (r == 22)
			return 32'h8000_0000;
		return $urandom;
	endfunction

	function automatic logic [DATA_W-1:0] pick_target();
		int r;
		int t;
		r = $urandom_range(0, 24);
		t = int'($urandom_range(0, 360)) - 60;
		if (r < 16)
			return DATA_W'(t);
		if (r < 19)
			return DATA_W'($urandom_range(0, 2000));
		if (r == 19)
			return 32'h8000_0000;
		if (r == 20)
			return 32'h7FFF_FFFF;
		if (r == 21)
			return '0;
		return $urandom;
	endfunction

	// offer one word, hold it until taken, then maybe go idle
	task automatic send_word(input op_t op, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] val);
		int gap;
		in_valid <= 1'b1;
		operation <= op;
		position <= pos;
		operand_value <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		op_count[int'(op)]++;
		gap = no_gaps ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic random_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			send_word(OP_ADD, pick_pos(), pick_delta());
		else if (r < 70)
			send_word(OP_SUM, pick_pos(), $urandom);
		else if (r < 98)
			send_word(OP_FIND, pick_pos(), pick_target());
		else
			send_word(OP_CLEAR, pick_pos(), $urandom);
	endtask

	// stop offering and wait until every answer word has come back
	task automatic drain_answers();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// only called while the block is idle
	task automatic write_size(input logic [SIZE_W-1:0] v);
		cfg_valid <= 1'b1;
		size_in_use <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cur_size = (v == 0) ? 1 : ((v > MAX_POS) ? MAX_POS : v);
	endtask

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		int n;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
				out_ready <= 1'b1;
			end else begin
				n = no_gaps ? 0 : idle_len();
				if (n > 0) begin
					out_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d answers outstanding", cycles, pending);
		$display("FAIL prefix_count_rank_select");
		$finish;
	end

	initial begin
		int v;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_ADD;
		position = '0;
		operand_value = '0;
		cfg_valid = 1'b0;
		size_in_use = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed words at the reset size; the block's clearing sweep after
		// reset just shows up as a long wait on in_ready
		send_word(OP_ADD,   11'd0,    32'd5);           // position 0 ignored
		send_word(OP_ADD,   11'd1,    32'h7FFF_FFFF);
		send_word(OP_ADD,   11'd1,    32'd1);           // node wraps negative
		send_word(OP_SUM,   11'd1,    32'hFFFF_FFFF);
		send_word(OP_ADD,   11'd1024, 32'h8000_0000);
		send_word(OP_ADD,   11'd1025, 32'd7);           // past the size, ignored
		send_word(OP_ADD,   11'd2047, 32'd9);           // ditto, all position bits set
		send_word(OP_SUM,   11'd0,    32'd0);
		send_word(OP_SUM,   11'd1024, 32'd0);
		send_word(OP_SUM,   11'd2047, 32'd0);           // clamped to the size
		send_word(OP_FIND,  11'd0,    32'h8000_0000);   // reached at once
		send_word(OP_FIND,  11'd0,    32'h7FFF_FFFF);   // never reached
		send_word(OP_CLEAR, 11'd2047, 32'hFFFF_FFFF);
		send_word(OP_FIND,  11'd0,    32'd0);
		send_word(OP_FIND,  11'd0,    32'd1);
		send_word(OP_ADD,   11'd512,  32'd3);
		send_word(OP_ADD,   11'd3,    32'd2);
		send_word(OP_FIND,  11'd0,    32'd5);
		send_word(OP_FIND,  11'd0,    32'd2);
		send_word(OP_SUM,   11'd511,  32'd0);
		send_word(OP_ADD,   11'd1000, 32'hFFFF_FFF0);
		send_word(OP_SUM,   11'd1023, 32'd0);

		// random phases; the store is kept across size changes on purpose
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_answers();
			v = (ph < PHASES - 1) ? size_plan[ph] : $urandom_range(2, MAX_POS);
			write_size(SIZE_W'(v));
			no_gaps = (ph % 3 == 2);
			for (int k = 0; k < PER_PHASE; k++) begin
				// receiver stalls long while words keep coming: block backs up
				if (ph == 4 && k == 10)
					long_hold = 1'b1;
				// sender waits out everything in flight mid-phase
				if (ph == 1 && k == PER_PHASE / 2)
					drain_answers();
				random_word();
			end
		end
		no_gaps = 1'b0;
		drain_answers();
		// catch any stray answer word that would trail the last one
		repeat (200) @(posedge clk);

		$display("Ran %0d add, %0d sum, %0d find, %0d clear words across %0d size settings",
			op_count[OP_ADD], op_count[OP_SUM], op_count[OP_FIND], op_count[OP_CLEAR],
			PHASES + 1);
		$display("%0d answers compared, %0d mismatched, %0d outstanding",
			answers_checked, mismatches, pending);
		if (mismatches == 0 && pending == 0)
			$display("PASS prefix_count_rank_select");
		else
			$display("FAIL prefix_count_rank_select");
		$finish;
	end

endmodule

@@ files.f @@
rtl/pcrs_pkg.sv
rtl/pcrs_ram.sv
rtl/pcrs_ctrl.sv
rtl/prefix_count_rank_select.sv
tb/sv/prefix_count_checker.sv
tb/sv/tb_prefix_count_rank_select.sv
